/* rtl/fewt_pkg.sv */
// Shared types, constants and the sine table function of the feedback echo block.
package fewt_pkg;

  localparam int DefSampleBits = 24;
  localparam int DefDelayDepth = 32768;
  localparam int DefSineDepth  = 1024;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int GainW    = 17;
  localparam int WetW     = 7;
  localparam int DelayW   = 15;
  localparam int PeriodW  = 20;
  localparam int StepW    = 16;
  localparam int PhaseW   = 22;
  localparam int SineW    = 16;
  localparam int GainFrac = 16;
  localparam int SineFrac = 15;

  localparam int PercentFull = 100;
  // half of 100 * 65536, rounding offset of the mix gain
  localparam int MixRound    = 3276800;

  localparam logic [GainW-1:0]   RstOutGain  = 17'd32768;
  localparam logic [GainW-1:0]   RstFbGain   = 17'd32768;
  localparam logic [WetW-1:0]    RstWet      = 7'd50;
  localparam logic [DelayW-1:0]  RstDelay    = 15'd9600;
  localparam logic [PeriodW-1:0] RstPeriod   = 20'd480000;
  localparam logic [StepW-1:0]   RstStep     = 16'd9;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BYPASS      = 3'd0,
    REG_OUT_GAIN    = 3'd1,
    REG_FB_GAIN     = 3'd2,
    REG_WET         = 3'd3,
    REG_DELAY       = 3'd4,
    REG_TREM_ON     = 3'd5,
    REG_TREM_PERIOD = 3'd6,
    REG_TREM_STEP   = 3'd7
  } fewt_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_GAIN,
    ST_MAG,
    ST_RECIP,
    ST_FIX,
    ST_TREM,
    ST_DONE
  } fewt_state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic read;
    logic mul;
    logic sum;
    logic gain;
    logic mag;
    logic recip;
    logic fix;
    logic trem;
    logic done;
  } fewt_cmd_t;

  typedef struct packed {
    logic bypass;
    logic trem_on;
    logic d_ge_depth;
    logic out_busy;
  } fewt_sts_t;

  // t: phase with one full turn = 2^32; Q30 Taylor series per quadrant
  function automatic logic [SineW-1:0] sine_entry(input logic [63:0] t);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] t5;
    logic [63:0] t6;
    logic [63:0] sp;
    logic [63:0] sn;
    logic [63:0] res;
    quad = t[31:30];
    r    = {34'd0, t[29:0]};
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x   = (r * HalfPiQ30) >> 30;
    x2  = (x * x) >> 30;
    t1  = ((x * x2) >> 30) / 64'd6;
    t2  = ((t1 * x2) >> 30) / 64'd20;
    t3  = ((t2 * x2) >> 30) / 64'd42;
    t4  = ((t3 * x2) >> 30) / 64'd72;
    t5  = ((t4 * x2) >> 30) / 64'd110;
    t6  = ((t5 * x2) >> 30) / 64'd156;
    sp  = x + t2 + t4 + t6;
    sn  = t1 + t3 + t5;
    res = (sp > sn) ? sp - sn : 64'd0;
    res = (res + (64'd1 << 14)) >> 15;
    if (res > 64'd32767) begin
      res = 64'd32767;
    end
    return quad[1] ? SineW'(64'd0 - res) : SineW'(res);
  endfunction

endpackage

/* rtl/fewt_rndsat.sv */
// Round-to-nearest shift of a signed product, plus an addend, saturated to sample width.
module fewt_rndsat #(
  parameter int W  = 42,
  parameter int S  = 16,
  parameter int SB = 24
) (
  input  logic signed [W-1:0]  value_i,
  input  logic signed [SB-1:0] addend_i,
  output logic signed [SB-1:0] result_o
);

  localparam int TW = W + 2;
  localparam logic signed [TW-1:0] HiLim = TW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [TW-1:0] LoLim = -HiLim - TW'(1);

  logic [W-1:0]           mag;
  logic [W:0]             rnd;
  logic [W:0]             quo;
  logic signed [TW-1:0]   sgn;
  logic signed [TW-1:0]   tot;

  always_comb begin
    mag = value_i[W-1] ? W'(-value_i) : W'(value_i);
    rnd = (W+1)'(mag) + ((W+1)'(1) << (S - 1));
    quo = rnd >> S;
    sgn = value_i[W-1] ? -$signed(TW'(quo)) : $signed(TW'(quo));
    tot = sgn + TW'(addend_i);
    if (tot > HiLim) begin
      result_o = SB'(HiLim);
    end else if (tot < LoLim) begin
      result_o = SB'(LoLim);
    end else begin
      result_o = SB'(tot);
    end
  end

endmodule

/* rtl/fewt_ctrl.sv */
// Sequencing state machine of the echo and tremolo datapath.
module fewt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output fewt_pkg::fewt_cmd_t cmd_o,
  input  fewt_pkg::fewt_sts_t sts_i
);
  import fewt_pkg::*;

  fewt_state_e state_q;
  fewt_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.bypass ? ST_GAIN : ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sts_i.d_ge_depth) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_GAIN;
      ST_GAIN:  state_d = sts_i.bypass ? ST_DONE : ST_MAG;
      ST_MAG:   state_d = ST_RECIP;
      ST_RECIP: state_d = ST_FIX;
      ST_FIX:   state_d = sts_i.trem_on ? ST_TREM : ST_DONE;
      ST_TREM:  state_d = ST_DONE;
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MOD:   cmd_o.mod_step = sts_i.d_ge_depth;
      ST_READ:  cmd_o.read     = 1'b1;
      ST_MUL:   cmd_o.mul      = 1'b1;
      ST_SUM:   cmd_o.sum      = 1'b1;
      ST_GAIN:  cmd_o.gain     = 1'b1;
      ST_MAG:   cmd_o.mag      = 1'b1;
      ST_RECIP: cmd_o.recip    = 1'b1;
      ST_FIX:   cmd_o.fix      = 1'b1;
      ST_TREM:  cmd_o.trem     = 1'b1;
      ST_DONE:  cmd_o.done     = !sts_i.out_busy;
      default:  cmd_o          = '0;
    endcase
  end

endmodule

/* rtl/fewt_datapath.sv */
// Datapath: config registers, delay store, mix and gain arithmetic, sine table, output register.
module fewt_datapath #(
  parameter int SampleBits = fewt_pkg::DefSampleBits,
  parameter int DelayDepth = fewt_pkg::DefDelayDepth,
  parameter int SineDepth  = fewt_pkg::DefSineDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fewt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fewt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic signed [SampleBits-1:0]  sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SampleBits-1:0]  sample_out_o,
  input  fewt_pkg::fewt_cmd_t           cmd_i,
  output fewt_pkg::fewt_sts_t           sts_o
);
  import fewt_pkg::*;

  localparam int SB   = SampleBits;
  localparam int AW   = $clog2(DelayDepth);
  localparam int IW   = $clog2(SineDepth);
  localparam int MixW = SB + 8;
  localparam int GpW  = MixW + 18;
  localparam int FbW  = SB + 18;
  localparam int TpW  = SB + SineW;
  localparam int NW   = SB + 7;
  localparam int QW   = NW - 6;
  localparam logic [NW-1:0] RecipM    = NW'((64'd1 << NW) / 64'd100);
  localparam logic [QW-1:0] HalfScale = QW'(1) << (SB - 1);
  localparam logic signed [SB-1:0] SampleMax = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SampleMin = {1'b1, {(SB-1){1'b0}}};

  // configuration
  logic                bypass_q;
  logic [GainW-1:0]    out_gain_q;
  logic [GainW-1:0]    fb_gain_q;
  logic [WetW-1:0]     wet_q;
  logic [DelayW-1:0]   delay_q;
  logic                trem_on_q;
  logic [PeriodW-1:0]  trem_period_q;
  logic [StepW-1:0]    trem_step_q;

  // control state
  logic [AW-1:0]       wp_q;
  logic                wrapped_q;
  logic [PeriodW-1:0]  trem_pos_q;
  logic                out_valid_q;

  // item payload
  logic signed [SB-1:0]   x_q;
  logic [DelayW-1:0]      d_q;
  logic signed [SB-1:0]   rdata_q;
  logic                   rvalid_q;
  logic [PhaseW-1:0]      ph_q;
  logic [IW-1:0]          idx_q;
  logic signed [SineW-1:0] sine_q;
  logic signed [FbW-1:0]  fbp_q;
  logic signed [MixW-1:0] mwa_q;
  logic signed [MixW-1:0] mwb_q;
  logic signed [MixW-1:0] mix_q;
  logic signed [GpW-1:0]  gp_q;
  logic                   neg_q;
  logic [NW-1:0]          n_q;
  logic [QW-1:0]          qe_q;
  logic signed [SB-1:0]   y_q;
  logic signed [TpW-1:0]  tp_q;
  logic signed [SB-1:0]   sample_out_q;

  logic signed [SB-1:0] echo_mem [DelayDepth];
  logic [SineW-1:0]     sine_rom [SineDepth];

  for (genvar gi = 0; gi < SineDepth; gi++) begin : g_sine
    localparam logic [63:0] Phase = (64'(gi) << 32) / 64'(SineDepth);
    assign sine_rom[gi] = sine_entry(Phase);
  end

  logic [AW:0]            rd_sum;
  logic [AW-1:0]          rd_addr;
  logic                   d_ge_depth;
  logic [WetW-1:0]        wet_lim;
  logic [WetW-1:0]        dry;
  logic signed [SB-1:0]   del_s;
  logic signed [MixW-1:0] gop;
  logic [GpW-1:0]         gmag;
  logic [2*NW-1:0]        rprod;
  logic [NW-1:0]          rem_d;
  logic [QW-1:0]          q_d;
  logic signed [SB-1:0]   y_d;
  logic [PeriodW-1:0]     pos_inc;
  logic signed [SB-1:0]   fb_res;
  logic signed [SB-1:0]   byp_res;
  logic signed [SB-1:0]   trem_res;

  always_comb begin
    d_ge_depth = 32'(d_q) >= 32'(DelayDepth);
    rd_sum     = (AW+1)'(wp_q) + (AW+1)'(DelayDepth) - (AW+1)'(d_q);
    rd_addr    = (rd_sum >= (AW+1)'(DelayDepth)) ? AW'(rd_sum - (AW+1)'(DelayDepth))
                                                 : AW'(rd_sum);
    wet_lim    = (wet_q > WetW'(PercentFull)) ? WetW'(PercentFull) : wet_q;
    dry        = WetW'(PercentFull) - wet_lim;
    del_s      = rvalid_q ? rdata_q : '0;
    gop        = bypass_q ? MixW'(x_q) : mix_q;
    gmag       = gp_q[GpW-1] ? GpW'(-gp_q) : GpW'(gp_q);
    rprod      = (2*NW)'(n_q) * (2*NW)'(RecipM);
    rem_d      = n_q - NW'(NW'(qe_q) * NW'(PercentFull));
    q_d        = (rem_d >= NW'(PercentFull)) ? qe_q + QW'(1) : qe_q;
    if (neg_q) begin
      y_d = (q_d > HalfScale) ? SampleMin : SB'(SB'(0) - SB'(q_d));
    end else begin
      y_d = (q_d >= HalfScale) ? SampleMax : SB'(q_d);
    end
    pos_inc = trem_pos_q + PeriodW'(1);
    if (pos_inc >= trem_period_q) begin
      pos_inc = pos_inc - trem_period_q;
    end
  end

  fewt_rndsat #(.W(FbW), .S(GainFrac), .SB(SB)) u_fb_rnd (
    .value_i  (fbp_q),
    .addend_i (x_q),
    .result_o (fb_res)
  );

  fewt_rndsat #(.W(GpW), .S(GainFrac), .SB(SB)) u_byp_rnd (
    .value_i  (gp_q),
    .addend_i ('0),
    .result_o (byp_res)
  );

  fewt_rndsat #(.W(TpW), .S(SineFrac), .SB(SB)) u_trem_rnd (
    .value_i  (tp_q),
    .addend_i ('0),
    .result_o (trem_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q      <= 1'b0;
      out_gain_q    <= RstOutGain;
      fb_gain_q     <= RstFbGain;
      wet_q         <= RstWet;
      delay_q       <= RstDelay;
      trem_on_q     <= 1'b0;
      trem_period_q <= RstPeriod;
      trem_step_q   <= RstStep;
    end else if (cfg_we_i) begin
      unique case (fewt_reg_e'(cfg_idx_i))
        REG_BYPASS:      bypass_q      <= cfg_data_i[0];
        REG_OUT_GAIN:    out_gain_q    <= GainW'(cfg_data_i);
        REG_FB_GAIN:     fb_gain_q     <= GainW'(cfg_data_i);
        REG_WET:         wet_q         <= WetW'(cfg_data_i);
        REG_DELAY:       delay_q       <= DelayW'(cfg_data_i);
        REG_TREM_ON:     trem_on_q     <= cfg_data_i[0];
        REG_TREM_PERIOD: trem_period_q <= PeriodW'(cfg_data_i);
        REG_TREM_STEP:   trem_step_q   <= StepW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      trem_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sum) begin
        if (wp_q == AW'(DelayDepth - 1)) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + AW'(1);
        end
        if (trem_on_q) begin
          trem_pos_q <= pos_inc;
        end
      end
      if (cmd_i.done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // store entries below the write pointer, or all once it wrapped, hold written data
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rdata_q  <= echo_mem[rd_addr];
      rvalid_q <= wrapped_q || (rd_addr < wp_q);
    end
    if (cmd_i.sum) begin
      echo_mem[wp_q] <= fb_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sine_q <= SineW'(sine_rom[idx_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_in_i;
      d_q <= delay_q;
    end
    if (cmd_i.mod_step) begin
      d_q <= d_q - DelayW'(DelayDepth);
    end
    if (cmd_i.read) begin
      ph_q <= PhaseW'(36'(trem_pos_q) * 36'(trem_step_q));
    end
    if (cmd_i.mul) begin
      fbp_q <= FbW'(del_s) * FbW'($signed({1'b0, fb_gain_q}));
      mwa_q <= MixW'(x_q) * MixW'($signed({1'b0, dry}));
      mwb_q <= MixW'(del_s) * MixW'($signed({1'b0, wet_lim}));
      idx_q <= IW'((64'(ph_q) * 64'(SineDepth)) >> PhaseW);
    end
    if (cmd_i.sum) begin
      mix_q <= mwa_q + mwb_q;
    end
    if (cmd_i.gain) begin
      gp_q <= GpW'(gop) * GpW'($signed({1'b0, out_gain_q}));
    end
    if (cmd_i.mag) begin
      neg_q <= gp_q[GpW-1];
      n_q   <= NW'((gmag + GpW'(MixRound)) >> GainFrac);
    end
    if (cmd_i.recip) begin
      qe_q <= QW'(rprod >> NW);
    end
    if (cmd_i.fix) begin
      y_q <= y_d;
    end
    if (cmd_i.trem) begin
      tp_q <= TpW'(y_q) * TpW'(sine_q);
    end
    if (cmd_i.done) begin
      sample_out_q <= bypass_q ? byp_res : (trem_on_q ? trem_res : y_q);
    end
  end

  assign sts_o.bypass     = bypass_q;
  assign sts_o.trem_on    = trem_on_q;
  assign sts_o.d_ge_depth = d_ge_depth;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

`ifndef SYNTHESIS
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW+1)'(wp_q) < (AW+1)'(DelayDepth))
    else $error("write pointer out of store range");

  a_wp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.sum |=> $stable(wp_q))
    else $error("write pointer moved outside store write");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.sum |=> $stable(trem_pos_q))
    else $error("tremolo position moved outside store write");

  a_delay_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read |-> (32'(d_q) < 32'(DelayDepth)))
    else $error("delay not reduced below store depth at read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while held");
`endif

endmodule

/* rtl/feedback_echo_with_tremolo_core.sv */
// Top level of the feedback echo with tremolo: controller and datapath.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o   sample_in_i
//   out      out        out_valid_o / out_stall_i sample_out_o
//
// One item at a time. Bypass steps through idle, gain and done. Echo steps through idle,
// a modulo step for each whole DelayDepth in the delay, read, multiply, sum, gain,
// magnitude, reciprocal, fix, a tremolo step when enabled, and done; the store read is registered.
// Reset loads the config defaults and clears write pointer and tremolo position;
// unwritten store entries read as zero through a fill mark, so no clearing pass is needed.
// A result held by out_stall_i waits in the output register; the next item is still
// taken and only blocks at its final step.
module feedback_echo_with_tremolo_core #(
  parameter int SampleBits = fewt_pkg::DefSampleBits,
  parameter int DelayDepth = fewt_pkg::DefDelayDepth,
  parameter int SineDepth  = fewt_pkg::DefSineDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fewt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fewt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SampleBits-1:0]  sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SampleBits-1:0]  sample_out_o
);
  import fewt_pkg::*;

  fewt_cmd_t cmd;
  fewt_sts_t sts;

  fewt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fewt_datapath #(
    .SampleBits (SampleBits),
    .DelayDepth (DelayDepth),
    .SineDepth  (SineDepth)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for feedback_echo_with_tremolo_core: directed table, then random.
`timescale 1ns / 1ps

module tb_top;
  import fewt_pkg::*;

  localparam int      SB         = 24;
  localparam int      ECHO_DEPTH = 32768;
  localparam int      SINE_N     = 1024;
  localparam longint  SMP_MAX    = 8388607;
  localparam longint  SMP_MIN    = -8388608;
  localparam longint  UNITY      = 65536;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int      RAND_ITEMS = 1500;
  localparam int      HOLD_LEN   = 500;
  localparam int      DRAIN      = 40;
  localparam int      SHOW_MAX   = 10;

  typedef struct packed {
    logic                  is_reg;
    fewt_reg_e             idx;
    logic [CfgDataW-1:0]   val;
    logic signed [SB-1:0]  smp;
    logic                  typed;
    logic signed [SB-1:0]  want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [SB-1:0] sample_in_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [SB-1:0] sample_out_o;

  // mirror of the block's state and registers
  logic signed [SB-1:0] echo_mem [0:ECHO_DEPTH-1];
  int                   sine_tab [0:SINE_N-1];
  int                   wr_ptr;
  logic [19:0]          trem_pos;
  longint               m_bypass, m_out_gain, m_fb_gain, m_wet, m_delay, m_trem_on, m_step;
  logic [19:0]          m_period;

  logic signed [SB-1:0] due_samples [$];
  logic signed [SB-1:0] mon_want;
  dir_row_t             dir_tab [$];
  int                   n_bad;
  int                   n_sent;
  int                   n_checked;
  int                   n_writes;
  int                   n_phases;
  int                   burst_left;
  bit                   calm;
  bit                   hold_req;

  feedback_echo_with_tremolo_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("tb_top: timeout, %0d items in, %0d out", n_sent, n_checked);
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic int sine_q15(int unsigned i);
    logic [63:0] t, r, x, x2, term, pos, neg, mag;
    logic [1:0]  quad;
    int          k;
    t    = (64'(i) << 32) / 64'(SINE_N);
    quad = t[31:30];
    r    = {34'd0, t[29:0]};
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    mag = (pos > neg) ? pos - neg : 64'd0;
    mag = (mag + (64'd1 << 14)) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip_sample(longint v);
    if (v > SMP_MAX) begin
      return SMP_MAX;
    end
    if (v < SMP_MIN) begin
      return SMP_MIN;
    end
    return v;
  endfunction

  function automatic void mirror_reset();
    int i;
    for (i = 0; i < SINE_N; i++) begin
      sine_tab[i] = sine_q15(i);
    end
    for (i = 0; i < ECHO_DEPTH; i++) begin
      echo_mem[i] = '0;
    end
    wr_ptr     = 0;
    trem_pos   = '0;
    m_bypass   = 0;
    m_out_gain = 32768;
    m_fb_gain  = 32768;
    m_wet      = 50;
    m_delay    = 9600;
    m_trem_on  = 0;
    m_period   = 20'd480000;
    m_step     = 9;
  endfunction

  // one sample through echo, mix, gain and tremolo; updates the mirrored state
  function automatic logic signed [SB-1:0] echo_tremolo_step(logic signed [SB-1:0] s);
    longint      x, del, w, mix, y;
    int          rd;
    logic [63:0] ph;
    int          idx;
    logic [19:0] np;
    x = longint'(s);
    if (m_bypass != 0) begin
      y = clip_sample(round_div(x * m_out_gain, UNITY));
    end else begin
      rd  = (wr_ptr + ECHO_DEPTH - int'(m_delay % ECHO_DEPTH)) % ECHO_DEPTH;
      del = longint'(echo_mem[rd]);
      w   = (m_wet > 100) ? 100 : m_wet;
      echo_mem[wr_ptr] = SB'(clip_sample(x + round_div(del * m_fb_gain, UNITY)));
      wr_ptr = (wr_ptr + 1) % ECHO_DEPTH;
      mix = x * (100 - w) + del * w;
      y   = clip_sample(round_div(mix * m_out_gain, 100 * UNITY));
      if (m_trem_on != 0) begin
        ph  = (64'(trem_pos) * 64'(m_step)) & ((64'd1 << 22) - 64'd1);
        idx = int'((ph * 64'(SINE_N)) >> 22);
        y   = clip_sample(round_div(y * longint'(sine_tab[idx]), 32768));
        np  = trem_pos + 20'd1;
        if (np >= m_period) begin
          np = np - m_period;
        end
        trem_pos = np;
      end
    end
    return y[SB-1:0];
  endfunction

  function automatic void note_bad(string what, logic signed [SB-1:0] want,
                                   logic signed [SB-1:0] got);
    n_bad++;
    if (n_bad <= SHOW_MAX) begin
      $display("tb_top: %s at item %0d: expected %0d, got %0d", what, n_checked, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_samples.size() == 0) begin
        note_bad("unexpected sample", '0, sample_out_o);
      end else begin
        mon_want = due_samples.pop_front();
        if (sample_out_o !== mon_want) begin
          note_bad("sample mismatch", mon_want, sample_out_o);
        end
      end
      n_checked++;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : rx_stall
    int mode;
    int left;
    int hold;
    bit held;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 150);
        end
        left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic dir_row_t reg_row(fewt_reg_e idx, logic [CfgDataW-1:0] val);
    dir_row_t row;
    row        = '0;
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic dir_row_t smp_row(logic signed [SB-1:0] smp, logic typed,
                                       logic signed [SB-1:0] want);
    dir_row_t row;
    row       = '0;
    row.smp   = smp;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic void add_row(dir_row_t row);
    dir_tab = {dir_tab, row};
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_samples.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(fewt_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    n_writes++;
    case (idx)
      REG_BYPASS:      m_bypass   = longint'(val[0]);
      REG_OUT_GAIN:    m_out_gain = longint'(val[16:0]);
      REG_FB_GAIN:     m_fb_gain  = longint'(val[16:0]);
      REG_WET:         m_wet      = longint'(val[6:0]);
      REG_DELAY:       m_delay    = longint'(val[14:0]);
      REG_TREM_ON:     m_trem_on  = longint'(val[0]);
      REG_TREM_PERIOD: m_period   = val[19:0];
      REG_TREM_STEP:   m_step     = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_phases++;
  endtask

  task automatic send_sample(logic signed [SB-1:0] s, logic typed, logic signed [SB-1:0] want);
    int                   gap;
    logic signed [SB-1:0] calc;
    if (burst_left == 0) begin
      gap        = calm ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    calc = echo_tremolo_step(s);
    due_samples = {due_samples, (typed ? want : calc)};
    n_sent++;
  endtask

  function automatic logic [CfgDataW-1:0] pick_value(fewt_reg_e idx);
    int c;
    c = $urandom_range(0, 5);
    case (idx)
      REG_BYPASS:   return CfgDataW'($urandom_range(0, 4) == 0);
      REG_TREM_ON:  return CfgDataW'($urandom_range(0, 1));
      REG_OUT_GAIN: begin
        case (c)
          0:       return CfgDataW'(0);
          1:       return CfgDataW'(65536);
          2:       return CfgDataW'(131071);
          default: return CfgDataW'($urandom_range(0, 80000));
        endcase
      end
      REG_FB_GAIN: begin
        case (c)
          0:       return CfgDataW'(0);
          1:       return CfgDataW'(65536);
          2:       return CfgDataW'(131071);
          default: return CfgDataW'($urandom_range(0, 65536));
        endcase
      end
      REG_WET: begin
        case (c)
          0:       return CfgDataW'(0);
          1:       return CfgDataW'(100);
          2:       return CfgDataW'(127);
          default: return CfgDataW'($urandom_range(0, 127));
        endcase
      end
      REG_DELAY: begin
        case (c)
          0:       return CfgDataW'(0);
          1:       return CfgDataW'(1);
          2:       return CfgDataW'(32767);
          3:       return CfgDataW'($urandom_range(1, 32767));
          default: return CfgDataW'($urandom_range(1, 64));
        endcase
      end
      REG_TREM_PERIOD: begin
        case (c)
          0:       return CfgDataW'(0);
          1:       return CfgDataW'(1);
          2:       return 20'hFFFFF;
          3:       return CfgDataW'($urandom_range(1, 20'hFFFFF));
          default: return CfgDataW'($urandom_range(1, 64));
        endcase
      end
      default: begin
        case (c)
          0:       return CfgDataW'(0);
          1:       return CfgDataW'(65535);
          default: return CfgDataW'($urandom_range(0, 65535));
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2, 3:    return SB'(int'($urandom_range(0, 4000)) - 2000);
      default: return SB'($urandom());
    endcase
  endfunction

  initial begin : stim
    bit        writing;
    int        n;
    int        goal;
    fewt_reg_e r;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    n_bad       = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_writes    = 0;
    n_phases    = 0;
    burst_left  = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    writing     = 1'b0;
    mirror_reset();

    // after reset: dry/wet half each, empty store, so out = in / 4
    add_row(smp_row(24'sd8388607, 1'b1, 24'sd2097152));
    add_row(smp_row(-24'sd8388608, 1'b1, -24'sd2097152));
    add_row(smp_row(24'sd0, 1'b1, 24'sd0));
    add_row(smp_row(24'sd2, 1'b1, 24'sd1));
    add_row(smp_row(-24'sd2, 1'b1, -24'sd1));
    add_row(smp_row(-24'sd1, 1'b1, 24'sd0));
    add_row(reg_row(REG_BYPASS, 1));
    add_row(reg_row(REG_OUT_GAIN, 65536));
    add_row(smp_row(24'sd8388607, 1'b1, 24'sd8388607));
    add_row(smp_row(-24'sd8388608, 1'b1, -24'sd8388608));
    add_row(reg_row(REG_OUT_GAIN, 131071));
    add_row(smp_row(24'sd8388607, 1'b1, 24'sd8388607));
    add_row(smp_row(-24'sd8388608, 1'b1, -24'sd8388608));
    add_row(smp_row(24'sd1, 1'b1, 24'sd2));
    add_row(smp_row(-24'sd1, 1'b1, -24'sd2));
    add_row(reg_row(REG_OUT_GAIN, 0));
    add_row(smp_row(24'sd12345, 1'b1, 24'sd0));
    // echo, wet above 100, shortest delay, unity feedback
    add_row(reg_row(REG_BYPASS, 0));
    add_row(reg_row(REG_OUT_GAIN, 65536));
    add_row(reg_row(REG_FB_GAIN, 65536));
    add_row(reg_row(REG_WET, 127));
    add_row(reg_row(REG_DELAY, 1));
    add_row(smp_row(24'sd100, 1'b0, '0));
    add_row(smp_row(24'sd5000, 1'b0, '0));
    // zero delay means the full store length
    add_row(reg_row(REG_DELAY, 0));
    add_row(smp_row(24'sd7, 1'b0, '0));
    add_row(smp_row(-24'sd7, 1'b0, '0));
    // tremolo with a short period, so the position wraps
    add_row(reg_row(REG_TREM_ON, 1));
    add_row(reg_row(REG_TREM_PERIOD, 3));
    add_row(reg_row(REG_TREM_STEP, 65535));
    add_row(reg_row(REG_WET, 40));
    add_row(reg_row(REG_FB_GAIN, 40000));
    add_row(smp_row(24'sd8388607, 1'b0, '0));
    add_row(smp_row(-24'sd8388608, 1'b0, '0));
    add_row(smp_row(24'sd300000, 1'b0, '0));
    add_row(smp_row(-24'sd4000000, 1'b0, '0));
    // zero step stays on sine entry 0, zero period never wraps
    add_row(reg_row(REG_TREM_PERIOD, 0));
    add_row(reg_row(REG_TREM_STEP, 0));
    add_row(smp_row(24'sd1234567, 1'b1, 24'sd0));
    add_row(smp_row(-24'sd7654321, 1'b1, 24'sd0));
    // all dry at unity gain: out = in
    add_row(reg_row(REG_TREM_ON, 0));
    add_row(reg_row(REG_WET, 0));
    add_row(reg_row(REG_DELAY, 32767));
    add_row(reg_row(REG_FB_GAIN, 131071));
    add_row(smp_row(24'sd8388607, 1'b1, 24'sd8388607));
    add_row(smp_row(-24'sd8388608, 1'b1, -24'sd8388608));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        if (!writing) begin
          wait_idle();
        end
        writing = 1'b1;
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        if (writing) begin
          end_writes();
        end
        writing = 1'b0;
        send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    goal = n_sent + RAND_ITEMS;
    while (n_sent < goal) begin
      wait_idle();
      r = r.first();
      do begin
        if (n_phases == 6 || $urandom_range(0, 1) == 0) begin
          write_reg(r, pick_value(r));
        end
        r = r.next();
      end while (r != r.first());
      end_writes();
      calm = ($urandom_range(0, 3) == 0);
      n    = $urandom_range(20, 120);
      if (n_phases == 10) begin
        // long receiver hold-off while items keep coming
        hold_req = 1'b1;
        calm     = 1'b1;
        n        = 200;
      end
      repeat (n) send_sample(rand_sample(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_samples.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN) @(negedge clk_i);
    if (due_samples.size() != 0) begin
      n_bad++;
    end
    $display("tb_top: %0d samples in, %0d checked, %0d register writes over %0d settings",
             n_sent, n_checked, n_writes, n_phases);
    $display("tb_top: covered bypass, echo, tremolo wrap, delay and gain extremes, %0d bad",
             n_bad);
    if (n_bad == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/fewt_pkg.sv
rtl/fewt_rndsat.sv
rtl/fewt_ctrl.sv
rtl/fewt_datapath.sv
rtl/feedback_echo_with_tremolo_core.sv
tb/sv/tb_top.sv
